/* hw/rtl/vpg_pkg.sv */
// Package for the VLIW packet grouper: unit class codes, latency reset
// values, the CSR index type and the result item struct.
// No dependencies.
package vpg_pkg;

   localparam int NUM_UNITS = 7;

   // unit class codes; code 7 names no unit
   localparam logic [2:0] UNIT_ADD   = 3'd0;
   localparam logic [2:0] UNIT_MUL   = 3'd1;
   localparam logic [2:0] UNIT_FADD  = 3'd2;
   localparam logic [2:0] UNIT_FMUL  = 3'd3;
   localparam logic [2:0] UNIT_LOAD  = 3'd4;
   localparam logic [2:0] UNIT_STORE = 3'd5;
   localparam logic [2:0] UNIT_LOGIC = 3'd6;

   typedef logic [2:0] unit_class_type;
   typedef logic [2:0] csr_index_type;
   typedef logic [5:0] latency_type;

   // latency register reset values, indexed by unit class
   localparam latency_type LAT_RESET [NUM_UNITS] = '{
      6'd6, 6'd12, 6'd18, 6'd30, 6'd1, 6'd1, 6'd1
   };

   // one closed packet
   typedef struct packed {
      logic [31:0] start_cycle;
      logic [31:0] end_cycle;
      logic [6:0]  slot_mask;
      logic [15:0] first_index;
      logic [2:0]  instr_count;
      logic        last_of_run;
   } packet_type;

endpackage

/* hw/rtl/vliw_packet_grouper.sv */
// Greedy VLIW packet grouper: packs decoded instructions into seven-slot
// packets and emits each closed packet with its issue window.
// Depends on vpg_pkg.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | unit_class, regs, has_src2, last_instr
//   rsp     | out       | rsp_valid/rsp_stall | cycles, slot_mask, first_index, count, last_of_run
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data (latencies)
//
// An item is taken into an input register and resolved from there; one item
// per cycle is accepted while the result queue has room. An item yields up to
// two results, drained one per cycle while rsp_stall is low from a four-entry
// queue, so items closing two packets go no faster than their results drain.
// The input register advances only when the queue has room for two. Synchronous
// reset clears counters and packet state, sets the issue cycle to 1 and loads
// the reset latencies. csr_ready is always high; each write is registered.
module vliw_packet_grouper #(
   parameter int NUM_REGS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // instruction items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vpg_pkg::unit_class_type req_unit_class,
   input  logic [4:0]             req_dest_reg,
   input  logic [4:0]             req_src1_reg,
   input  logic                   req_has_src2,
   input  logic [4:0]             req_src2_reg,
   input  logic                   req_last_instr,
   // packet items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_start_cycle,
   output logic [31:0]            rsp_end_cycle,
   output logic [6:0]             rsp_slot_mask,
   output logic [15:0]            rsp_first_index,
   output logic [2:0]             rsp_instr_count,
   output logic                   rsp_last_of_run,
   // latency registers
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  vpg_pkg::csr_index_type csr_index,
   input  vpg_pkg::latency_type   csr_data
);
   import vpg_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // one-hot register bit, empty for indices beyond the register file
   function automatic logic [NUM_REGS-1:0] reg_bit(input logic [4:0] idx);
      logic [NUM_REGS-1:0] v;
      v = '0;
      if (32'(idx) < NUM_REGS) begin
         v = NUM_REGS'(1) << idx;
      end
      return v;
   endfunction

   // latency registers
   latency_type lat_ff [NUM_UNITS];

   // input register
   logic           in_valid_ff, in_valid_in;
   unit_class_type cls_ff;
   logic [4:0]     dest_ff, src1_ff, src2_ff;
   logic           has_src2_ff, last_ff;

   // open packet state
   logic [NUM_REGS-1:0] wmask_ff, wmask_in;
   logic [NUM_REGS-1:0] rmask_ff, rmask_in;
   logic [6:0]          busy_ff, busy_in;
   latency_type         maxlat_ff, maxlat_in;
   logic [31:0]         cyc_ff, cyc_in;
   logic [15:0]         first_ff, first_in;
   logic [2:0]          size_ff, size_in;
   logic [15:0]         nidx_ff, nidx_in;

   // result queue
   packet_type          q_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic                accept, advance, pop;
   logic                cls_ok, hazard, close1, flush;
   logic [6:0]          ubit;
   logic [NUM_REGS-1:0] dbit, srcs;
   latency_type         lat_sel, base_lat, lat_new;
   logic [NUM_REGS-1:0] base_w, base_r;
   logic [6:0]          base_busy, busy_new;
   logic [2:0]          base_size, size_new;
   logic [15:0]         first_new;
   logic [6:0]          close_off, flush_off;
   logic [7:0]          end2_off, cyc_off;
   packet_type          pkt_a, pkt_b, push0;
   logic [1:0]          push_n;

   assign accept    = req_valid && !req_stall;
   assign advance   = in_valid_ff && (cnt_ff <= CNT_W'(DEPTH - 2));
   assign req_stall = in_valid_ff && !advance;
   assign pop       = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   // hold latency registers, write on csr handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_UNITS; i++) begin
            lat_ff[i] <= LAT_RESET[i];
         end
      end else if (csr_valid && csr_ready) begin
         for (int i = 0; i < NUM_UNITS; i++) begin
            if (csr_index == csr_index_type'(i)) begin
               lat_ff[i] <= csr_data;
            end
         end
      end
   end

   // load input register on accept, drop it when resolved
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cls_ff      <= req_unit_class;
         dest_ff     <= req_dest_reg;
         src1_ff     <= req_src1_reg;
         has_src2_ff <= req_has_src2;
         src2_ff     <= req_src2_reg;
         last_ff     <= req_last_instr;
      end
   end

   // decode the held instruction
   always_comb begin
      cls_ok  = (cls_ff < unit_class_type'(NUM_UNITS));
      ubit    = cls_ok ? (7'(1) << cls_ff) : 7'd0;
      dbit    = cls_ok ? reg_bit(dest_ff) : '0;
      srcs    = '0;
      if (cls_ok) begin
         srcs = reg_bit(src1_ff) | (has_src2_ff ? reg_bit(src2_ff) : '0);
      end
      lat_sel = '0;
      for (int i = 0; i < NUM_UNITS; i++) begin
         if (cls_ff == unit_class_type'(i)) begin
            lat_sel = lat_ff[i];
         end
      end
   end

   // detect hazards against the open packet and merge the instruction
   always_comb begin
      hazard = |(busy_ff & ubit) || |(wmask_ff & (srcs | dbit)) ||
               |(rmask_ff & dbit);
      close1 = cls_ok && hazard && (size_ff != 3'd0);

      base_w    = close1 ? '0 : wmask_ff;
      base_r    = close1 ? '0 : rmask_ff;
      base_busy = close1 ? 7'd0 : busy_ff;
      base_lat  = close1 ? 6'd0 : maxlat_ff;
      base_size = close1 ? 3'd0 : size_ff;

      busy_new  = base_busy | ubit;
      lat_new   = (cls_ok && lat_sel > base_lat) ? lat_sel : base_lat;
      size_new  = cls_ok ? base_size + 3'd1 : base_size;
      first_new = (cls_ok && base_size == 3'd0) ? nidx_ff : first_ff;
      flush     = last_ff && (size_new != 3'd0);

      // narrow offsets keep one wide add per cycle value
      close_off = close1 ? {1'b0, maxlat_ff} + 7'd1 : 7'd0;
      flush_off = flush ? {1'b0, lat_new} + 7'd1 : 7'd0;
      end2_off  = {1'b0, close_off} + {2'b00, lat_new};
      cyc_off   = {1'b0, close_off} + {1'b0, flush_off};
   end

   // form the packet items
   always_comb begin
      pkt_a.start_cycle = cyc_ff;
      pkt_a.end_cycle   = cyc_ff + {26'd0, maxlat_ff};
      pkt_a.slot_mask   = busy_ff;
      pkt_a.first_index = first_ff;
      pkt_a.instr_count = size_ff;
      pkt_a.last_of_run = !flush;

      pkt_b.start_cycle = cyc_ff + {25'd0, close_off};
      pkt_b.end_cycle   = cyc_ff + {24'd0, end2_off};
      pkt_b.slot_mask   = busy_new;
      pkt_b.first_index = first_new;
      pkt_b.instr_count = size_new;
      pkt_b.last_of_run = 1'b1;

      push0  = close1 ? pkt_a : pkt_b;
      push_n = {1'b0, close1} + {1'b0, flush};
   end

   // advance the open packet state
   always_comb begin
      wmask_in  = wmask_ff;
      rmask_in  = rmask_ff;
      busy_in   = busy_ff;
      maxlat_in = maxlat_ff;
      cyc_in    = cyc_ff;
      first_in  = first_ff;
      size_in   = size_ff;
      nidx_in   = nidx_ff;
      if (advance) begin
         wmask_in  = base_w | dbit;
         rmask_in  = base_r | srcs;
         busy_in   = busy_new;
         maxlat_in = lat_new;
         cyc_in    = cyc_ff + {24'd0, cyc_off};
         first_in  = first_new;
         size_in   = size_new;
         nidx_in   = cls_ok ? nidx_ff + 16'd1 : nidx_ff;
         if (flush) begin
            wmask_in  = '0;
            rmask_in  = '0;
            busy_in   = 7'd0;
            maxlat_in = 6'd0;
            size_in   = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wmask_ff  <= '0;
         rmask_ff  <= '0;
         busy_ff   <= 7'd0;
         maxlat_ff <= 6'd0;
         cyc_ff    <= 32'd1;
         first_ff  <= 16'd0;
         size_ff   <= 3'd0;
         nidx_ff   <= 16'd0;
      end else begin
         wmask_ff  <= wmask_in;
         rmask_ff  <= rmask_in;
         busy_ff   <= busy_in;
         maxlat_ff <= maxlat_in;
         cyc_ff    <= cyc_in;
         first_ff  <= first_in;
         size_ff   <= size_in;
         nidx_ff   <= nidx_in;
      end
   end

   // push up to two packets, pop one per handshake
   always_ff @(posedge clock) begin
      if (advance && push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= push0;
         if (push_n == 2'd2) begin
            q_ff[wr_ptr_ff + PTR_W'(1)] <= pkt_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (advance) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_n);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         cnt_ff <= cnt_ff + (advance ? CNT_W'(push_n) : CNT_W'(0))
                          - (pop ? CNT_W'(1) : CNT_W'(0));
      end
   end

   assign rsp_valid       = (cnt_ff != '0);
   assign rsp_start_cycle = q_ff[rd_ptr_ff].start_cycle;
   assign rsp_end_cycle   = q_ff[rd_ptr_ff].end_cycle;
   assign rsp_slot_mask   = q_ff[rd_ptr_ff].slot_mask;
   assign rsp_first_index = q_ff[rd_ptr_ff].first_index;
   assign rsp_instr_count = q_ff[rd_ptr_ff].instr_count;
   assign rsp_last_of_run = q_ff[rd_ptr_ff].last_of_run;

   // queue never overflows
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");

   // a stalled held instruction keeps its fields
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(cls_ff) &&
                                     $stable(dest_ff) && $stable(last_ff)))
      else $error("held instruction changed while stalled");

   // an empty open packet has no busy slot and no latency
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (size_ff == 3'd0) |-> (busy_ff == 7'd0 && maxlat_ff == 6'd0))
      else $error("empty packet carries state");

   // two results only when a hazard closed a packet and a flush followed
   a_two: assert property (@(posedge clock) disable iff (reset)
      (advance && push_n == 2'd2) |-> (close1 && last_ff && cnt_ff <= CNT_W'(DEPTH - 2)))
      else $error("double push without close and flush");

endmodule

/* test/tb_top.sv */
// Testbench for the VLIW packet grouper: a directed table, then phases of random
// instruction streams under changing latencies, every packet checked against a model.
// Depends on vpg_pkg and vliw_packet_grouper.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vpg_pkg::*;

   localparam int NUM_REGS         = 32;
   localparam int NUM_DIR          = 22;
   localparam int NUM_PHASES       = 9;
   localparam int INSTRS_PER_PHASE = 104;
   localparam int RESET_CYCLES     = 12;
   localparam int SETTLE_CYCLES    = 8;
   localparam int HOLD_CYCLES      = 80;

   localparam unit_class_type UNIT_NONE  = 3'd7;
   localparam csr_index_type  CSR_UNUSED = 3'd7;
   localparam latency_type    LAT_ZERO   = 6'd0;
   localparam latency_type    LAT_MIN    = 6'd1;
   localparam latency_type    LAT_MAX    = 6'd63;

   typedef struct packed {
      unit_class_type cls;
      logic [4:0]     dst;
      logic [4:0]     src1;
      logic           has2;
      logic [4:0]     src2;
      logic           last;
   } instr_type;

   // one directed item, with a hand-written final packet where chk is set
   typedef struct packed {
      instr_type  it;
      logic       chk;
      packet_type pkt;
   } dir_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   unit_class_type         req_unit_class;
   logic [4:0]             req_dest_reg;
   logic [4:0]             req_src1_reg;
   logic                   req_has_src2;
   logic [4:0]             req_src2_reg;
   logic                   req_last_instr;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [31:0]            rsp_start_cycle;
   logic [31:0]            rsp_end_cycle;
   logic [6:0]             rsp_slot_mask;
   logic [15:0]            rsp_first_index;
   logic [2:0]             rsp_instr_count;
   logic                   rsp_last_of_run;
   logic                   csr_valid;
   logic                   csr_ready;
   csr_index_type          csr_index;
   latency_type            csr_data;

   vliw_packet_grouper #(.NUM_REGS(NUM_REGS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_unit_class  (req_unit_class),
      .req_dest_reg    (req_dest_reg),
      .req_src1_reg    (req_src1_reg),
      .req_has_src2    (req_has_src2),
      .req_src2_reg    (req_src2_reg),
      .req_last_instr  (req_last_instr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_start_cycle (rsp_start_cycle),
      .rsp_end_cycle   (rsp_end_cycle),
      .rsp_slot_mask   (rsp_slot_mask),
      .rsp_first_index (rsp_first_index),
      .rsp_instr_count (rsp_instr_count),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // bundling model state
   latency_type  lat_cfg [NUM_UNITS];
   logic [31:0]  wr_regs;
   logic [31:0]  rd_regs;
   logic [6:0]   busy_units;
   latency_type  pkt_lat;
   logic [31:0]  issue_cycle;
   logic [15:0]  pkt_first_idx;
   logic [2:0]   pkt_len;
   logic [15:0]  seq_idx;
   packet_type   packet_q [$];

   int errors;
   int instrs_sent;
   int burst_left;
   int packets_made;
   int full_packets;
   int double_items;
   int stalled_cycles;

   function automatic logic [31:0] reg_bit(input logic [4:0] idx);
      if (idx >= NUM_REGS) return 32'd0;
      return 32'd1 << idx;
   endfunction

   // emit the open packet and advance the issue cycle past it
   function automatic packet_type close_packet();
      packet_type p;
      p.start_cycle = issue_cycle;
      p.end_cycle   = issue_cycle + 32'(pkt_lat);
      p.slot_mask   = busy_units;
      p.first_index = pkt_first_idx;
      p.instr_count = pkt_len;
      p.last_of_run = 1'b0;
      issue_cycle   = issue_cycle + 32'(pkt_lat) + 32'd1;
      wr_regs       = '0;
      rd_regs       = '0;
      busy_units    = '0;
      pkt_lat       = '0;
      pkt_len       = '0;
      packets_made++;
      if (p.instr_count == 3'd7) full_packets++;
      return p;
   endfunction

   // place one instruction and queue the packets it closes
   task automatic predict_packets(input instr_type it);
      packet_type  made [2];
      int          n;
      logic [31:0] dbit;
      logic [31:0] sbits;
      logic [6:0]  ubit;
      logic        clash;
      n     = 0;
      dbit  = reg_bit(it.dst);
      sbits = reg_bit(it.src1) | (it.has2 ? reg_bit(it.src2) : 32'd0);
      if (it.cls != UNIT_NONE) begin
         ubit  = 7'd1 << it.cls;
         clash = |(busy_units & ubit) || |(wr_regs & sbits) ||
                 |(wr_regs & dbit) || |(rd_regs & dbit);
         if (clash && pkt_len != 0) begin
            made[n] = close_packet();
            n++;
         end
         if (pkt_len == 0) pkt_first_idx = seq_idx;
         busy_units = busy_units | ubit;
         wr_regs    = wr_regs | dbit;
         rd_regs    = rd_regs | sbits;
         if (lat_cfg[it.cls] > pkt_lat) pkt_lat = lat_cfg[it.cls];
         pkt_len = pkt_len + 3'd1;
         seq_idx = seq_idx + 16'd1;
      end
      if (it.last && pkt_len != 0) begin
         made[n] = close_packet();
         n++;
      end
      if (n > 0) made[n - 1].last_of_run = 1'b1;
      if (n == 2) double_items++;
      for (int i = 0; i < n; i++) packet_q = {packet_q, made[i]};
   endtask

   function automatic instr_type instr(input unit_class_type c, input logic [4:0] d,
                                       input logic [4:0] s1, input logic h,
                                       input logic [4:0] s2, input logic l);
      instr_type it;
      it.cls  = c;
      it.dst  = d;
      it.src1 = s1;
      it.has2 = h;
      it.src2 = s2;
      it.last = l;
      return it;
   endfunction

   function automatic packet_type pkt_exp(input logic [31:0] start, input logic [31:0] stop,
                                          input logic [6:0] mask, input logic [15:0] first,
                                          input logic [2:0] count);
      packet_type p;
      p.start_cycle = start;
      p.end_cycle   = stop;
      p.slot_mask   = mask;
      p.first_index = first;
      p.instr_count = count;
      p.last_of_run = 1'b1;
      return p;
   endfunction

   function automatic instr_type random_instr();
      instr_type it;
      it.cls  = unit_class_type'($urandom_range(0, 7));
      it.dst  = 5'($urandom);
      it.src1 = 5'($urandom);
      it.has2 = 1'($urandom);
      it.src2 = 5'($urandom);
      it.last = ($urandom_range(0, 7) == 0);
      return it;
   endfunction

   // offer one item until taken, then maybe end the burst with a gap
   task automatic send_item(input instr_type it, input logic chk = 1'b0,
                            input packet_type typed = '0);
      int        gap;
      instr_type junk;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_unit_class <= it.cls;
      req_dest_reg   <= it.dst;
      req_src1_reg   <= it.src1;
      req_has_src2   <= it.has2;
      req_src2_reg   <= it.src2;
      req_last_instr <= it.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_packets(it);
      if (chk) begin
         packet_q[packet_q.size() - 1] = typed;
      end
      if (it.cls != UNIT_NONE) instrs_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            junk = random_instr();
            @(negedge clock);
            req_valid      <= 1'b0;
            req_unit_class <= junk.cls;
            req_dest_reg   <= junk.dst;
            req_src1_reg   <= junk.src1;
            req_has_src2   <= junk.has2;
            req_src2_reg   <= junk.src2;
            req_last_instr <= junk.last;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // hazard-free run of distinct units, sometimes flushed at its end
   task automatic send_bundle();
      unit_class_type order [NUM_UNITS];
      unit_class_type swap;
      instr_type      it;
      int             n;
      int             j;
      for (int i = 0; i < NUM_UNITS; i++) order[i] = unit_class_type'(i);
      for (int i = NUM_UNITS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      n = $urandom_range(1, NUM_UNITS);
      for (int k = 0; k < n; k++) begin
         it.cls  = order[k];
         it.dst  = 5'(16 + 2 * k + $urandom_range(0, 1));
         it.src1 = 5'($urandom_range(0, 15));
         it.has2 = 1'($urandom);
         it.src2 = 5'($urandom_range(0, 15));
         it.last = (k == n - 1) && ($urandom_range(0, 2) == 0);
         send_item(it);
      end
   endtask

   task automatic write_latency(input csr_index_type idx, input latency_type val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx != CSR_UNUSED) lat_cfg[idx] = val;
   endtask

   // stop offering, wait for every packet, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (packet_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   // compare each accepted packet with the oldest prediction
   always @(posedge clock) begin
      packet_type want;
      if (!reset && req_valid && req_stall) stalled_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (packet_q.size() == 0) begin
            $display("%0t ns: unexpected packet, expected none, got start_cycle 0x%0h",
                     $time, rsp_start_cycle);
            errors++;
         end else begin
            want = packet_q.pop_front();
            check_field("start_cycle", want.start_cycle, rsp_start_cycle);
            check_field("end_cycle", want.end_cycle, rsp_end_cycle);
            check_field("slot_mask", 32'(want.slot_mask), 32'(rsp_slot_mask));
            check_field("first_index", 32'(want.first_index), 32'(rsp_first_index));
            check_field("instr_count", 32'(want.instr_count), 32'(rsp_instr_count));
            check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
         end
      end
   end

   // receiver back-pressure in epochs; every fifth epoch holds off for a long stretch
   initial begin : rsp_backpressure
      stall_mode_type mode;
      int             span;
      int             epoch;
      rsp_stall = 1'b0;
      epoch     = 0;
      forever begin
         span = $urandom_range(40, 300);
         if (epoch % 5 == 2) mode = STALL_HOLD;
         else mode = stall_mode_type'($urandom_range(0, 2));
         for (int c = 0; c < span; c++) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= (c < HOLD_CYCLES);
            endcase
         end
         epoch++;
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      dir_row_type dir_rows [NUM_DIR];
      latency_type lat_next [NUM_UNITS];
      int          phase_base;

      // hold every input at a known value
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_unit_class = UNIT_ADD;
      req_dest_reg   = '0;
      req_src1_reg   = '0;
      req_has_src2   = 1'b0;
      req_src2_reg   = '0;
      req_last_instr = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      errors         = 0;
      instrs_sent    = 0;
      burst_left     = 0;
      packets_made   = 0;
      full_packets   = 0;
      double_items   = 0;
      stalled_cycles = 0;
      for (int u = 0; u < NUM_UNITS; u++) lat_cfg[u] = LAT_RESET[u];
      wr_regs       = '0;
      rd_regs       = '0;
      busy_units    = '0;
      pkt_lat       = '0;
      issue_cycle   = 32'd1;
      pkt_first_idx = '0;
      pkt_len       = '0;
      seq_idx       = '0;

      // directed items at reset latencies
      dir_rows = '{
         '{instr(UNIT_ADD,   1,  2, 1,  3, 1), 1'b1, pkt_exp(1, 7, 7'h01, 0, 1)},
         '{instr(UNIT_MUL,   2,  3, 1,  4, 0), 1'b0, '0},
         '{instr(UNIT_FADD,  5,  6, 0,  0, 0), 1'b0, '0},
         '{instr(UNIT_FMUL,  7,  8, 1,  9, 0), 1'b0, '0},
         '{instr(UNIT_LOAD, 10, 11, 0,  0, 0), 1'b0, '0},
         '{instr(UNIT_STORE,12, 13, 1, 14, 0), 1'b0, '0},
         // packet of six, every slot but add, flushed
         '{instr(UNIT_LOGIC,31, 30, 1, 29, 1), 1'b1, pkt_exp(8, 38, 7'h7E, 1, 6)},
         '{instr(UNIT_ADD,   0,  0, 1,  0, 0), 1'b0, '0},
         // busy slot, RAW through the second source, WAW, WAR
         '{instr(UNIT_ADD,   1,  2, 0,  0, 0), 1'b1, pkt_exp(39, 45, 7'h01, 7, 1)},
         '{instr(UNIT_MUL,   3,  5, 1,  1, 0), 1'b1, pkt_exp(46, 52, 7'h01, 8, 1)},
         '{instr(UNIT_FADD,  3, 20, 0,  0, 0), 1'b1, pkt_exp(53, 65, 7'h02, 9, 1)},
         '{instr(UNIT_FMUL, 20, 21, 0,  0, 0), 1'b1, pkt_exp(66, 84, 7'h04, 10, 1)},
         '{instr(UNIT_LOAD, 31, 31, 1, 31, 1), 1'b1, pkt_exp(85, 115, 7'h18, 11, 2)},
         // unused unit: dropped, and no empty packet on a flush
         '{instr(UNIT_NONE,  1,  1, 1,  1, 0), 1'b0, '0},
         '{instr(UNIT_NONE,  0,  0, 0,  0, 1), 1'b0, '0},
         // ignored second source, then an unused unit flushing the packet
         '{instr(UNIT_STORE, 4,  5, 0,  4, 0), 1'b0, '0},
         '{instr(UNIT_LOGIC, 6,  7, 0,  4, 0), 1'b0, '0},
         '{instr(UNIT_NONE,  0,  0, 0,  0, 1), 1'b1, pkt_exp(116, 117, 7'h60, 13, 2)},
         // one instruction closing two packets
         '{instr(UNIT_LOAD,  8,  8, 0,  0, 0), 1'b0, '0},
         '{instr(UNIT_LOAD,  9,  8, 0,  0, 1), 1'b1, pkt_exp(120, 121, 7'h10, 16, 1)},
         '{instr(UNIT_ADD,   0,  1, 1,  2, 1), 1'b0, '0},
         '{instr(UNIT_LOGIC,31, 31, 1, 31, 1), 1'b0, '0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIR; i++)
         send_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].pkt);
      settle();

      // random phases, each under a fresh latency setting
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         for (int u = 0; u < NUM_UNITS; u++) begin
            case (phase)
               0:       lat_next[u] = LAT_MAX;
               1:       lat_next[u] = LAT_ZERO;
               2:       lat_next[u] = LAT_MIN;
               default: begin
                  if ($urandom_range(0, 4) == 0)
                     lat_next[u] = $urandom_range(0, 1) ? LAT_MAX : LAT_ZERO;
                  else
                     lat_next[u] = latency_type'($urandom_range(0, 63));
               end
            endcase
            write_latency(csr_index_type'(u), lat_next[u]);
         end
         if (phase == 3) write_latency(CSR_UNUSED, latency_type'($urandom));
         @(negedge clock);
         csr_valid <= 1'b0;

         phase_base = instrs_sent;
         while (instrs_sent - phase_base < INSTRS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 7) send_bundle();
            else send_item(random_instr());
         end
         settle();
      end

      $display("Run covered %0d instructions in %0d packets, %0d of them full, %0d closing two",
               instrs_sent, packets_made, full_packets, double_items);
      $display("over %0d latency settings, with the input held back for %0d cycles",
               NUM_PHASES + 1, stalled_cycles);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
